FILE: rtl/pfcm_pkg.sv
// ----------------------------------------------------------------------------
// pfcm_pkg
// Widths, register indexes and latency figures shared by the force-constant
// block and its divider lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package pfcm_pkg;

  // field widths
  localparam int SepW  = 18;          // separation component, Q.12
  localparam int KW    = 16;          // spring constant, Q8.8
  localparam int SqW   = 2 * SepW;    // r_i * r_j product
  localparam int N2W   = 36;          // |r|^2, unsigned
  localparam int NumW  = 56;          // signed numerator before the divide
  localparam int QuoW  = 26;          // quotient magnitude bits
  localparam int OutW  = 32;          // Q16.16 result entry
  localparam int AddrW = 3;           // config register index width

  localparam int MaxShells = 3;

  // divider lane: input stage, one stage per quotient bit, sign stage
  localparam int DivLat = QuoW + 2;
  // front end: products, spring products, numerator assembly
  localparam int PipeLat = 3 + DivLat;

  // configuration register indexes
  typedef logic [AddrW-1:0] reg_idx_t;
  localparam reg_idx_t RegCentral0    = 3'd0;
  localparam reg_idx_t RegCentral1    = 3'd1;
  localparam reg_idx_t RegCentral2    = 3'd2;
  localparam reg_idx_t RegTransverse0 = 3'd3;
  localparam reg_idx_t RegTransverse1 = 3'd4;
  localparam reg_idx_t RegTransverse2 = 3'd5;

endpackage

`default_nettype wire

FILE: rtl/pair_spring_force_constant_matrix_top.sv
// Pipeline: 3 front-end stages and 28 divider stages, with one restoring
//   step per quotient bit.
// Throughput: one pair per cycle; the whole pipeline holds on output stall.
// Reset: rst (synchronous) clears valid bits and spring registers to zero;
//   the datapath needs no reset.
// ----------------------------------------------------------------------------
// pair_spring_force_constant_matrix_top
// 3x3 force-constant block D = -k*P - kappa*(I - P) for one neighbor pair,
// evaluated as a single rounded quotient per entry in Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module pair_spring_force_constant_matrix_top #(
  parameter int NUM_SHELLS = 3
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // config write port
  input  wire logic                              cfg_we,
  input  wire logic [pfcm_pkg::AddrW-1:0]        cfg_addr,
  input  wire logic [pfcm_pkg::KW-1:0]           cfg_data,
  // input stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [55:0]                       s_tdata,  // sep_x, sep_y, sep_z, pad
  input  wire logic [2:0]                        s_tuser,  // shell
  // result stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [287:0]                           m_tdata,  // d_xx,d_xy,d_xz,d_yx,d_yy,
                                                           // d_yz,d_zx,d_zy,d_zz
  output logic [0:0]                             m_tuser   // zero_length
);
  import pfcm_pkg::*;

  localparam int PW = KW + 1 + SqW;   // kd * r_i r_j

  // spring registers
  logic signed [KW-1:0] k_reg   [0:MaxShells-1];
  logic signed [KW-1:0] kap_reg [0:MaxShells-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MaxShells; i++) begin
        k_reg[i]   <= '0;
        kap_reg[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_addr)
        RegCentral0:    k_reg[0]   <= cfg_data;
        RegCentral1:    k_reg[1]   <= cfg_data;
        RegCentral2:    k_reg[2]   <= cfg_data;
        RegTransverse0: kap_reg[0] <= cfg_data;
        RegTransverse1: kap_reg[1] <= cfg_data;
        RegTransverse2: kap_reg[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves unless the result is stalled
  logic en;
  logic vld [0:PipeLat-1];
  logic zr  [1:PipeLat-1];

  assign en       = !vld[PipeLat-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[PipeLat-1];

  // shell lookup
  logic signed [KW-1:0] k_sel, kap_sel;
  always_comb begin
    k_sel   = '0;
    kap_sel = '0;
    for (int i = 0; i < MaxShells; i++) begin
      if (i < NUM_SHELLS && s_tuser == 3'(i)) begin
        k_sel   = k_reg[i];
        kap_sel = kap_reg[i];
      end
    end
  end

  logic signed [SepW-1:0] rx, ry, rz;
  assign rx = s_tdata[SepW-1:0];
  assign ry = s_tdata[2*SepW-1:SepW];
  assign rz = s_tdata[3*SepW-1:2*SepW];

  // stage 1: pair products, spring difference
  logic signed [SqW-1:0] p1 [0:5];   // xx, xy, xz, yy, yz, zz
  logic signed [KW:0]    kd1;
  logic signed [KW-1:0]  kap1;
  logic                  z1;

  always_ff @(posedge clk) begin
    if (en) begin
      p1[0] <= rx * rx;
      p1[1] <= rx * ry;
      p1[2] <= rx * rz;
      p1[3] <= ry * ry;
      p1[4] <= ry * rz;
      p1[5] <= rz * rz;
      kd1   <= (KW+1)'(kap_sel) - (KW+1)'(k_sel);
      kap1  <= kap_sel;
      z1    <= (rx == '0) && (ry == '0) && (rz == '0);
    end
  end

  // stage 2: |r|^2 and kd * r_i r_j
  logic signed [PW-1:0] p2 [0:5];
  logic [N2W-1:0]       n2_2;
  logic signed [KW-1:0] kap2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) p2[i] <= kd1 * p1[i];
      n2_2 <= N2W'(p1[0][SqW-2:0]) + N2W'(p1[3][SqW-2:0]) + N2W'(p1[5][SqW-2:0]);
      kap2 <= kap1;
    end
  end

  // stage 3: subtract kappa*|r|^2 on the diagonal; zero vector gets 0/1
  logic signed [KW+N2W:0] kn2;
  logic signed [NumW-1:0] num3 [0:5];
  logic        [N2W-1:0]  den3;

  assign kn2 = kap2 * $signed({1'b0, n2_2});

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        if (n2_2 == '0) num3[i] <= '0;
        else if (i == 0 || i == 3 || i == 5)
          num3[i] <= NumW'(p2[i]) - NumW'(kn2);
        else
          num3[i] <= NumW'(p2[i]);
      end
      den3 <= (n2_2 == '0) ? N2W'(1) : n2_2;
    end
  end

  // valid and zero-flag delay lines
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PipeLat; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int i = 1; i < PipeLat; i++) vld[i] <= vld[i-1];
    end
  end

  // zero flag joins at stage 2, slot i lines up with vld[i]
  always_ff @(posedge clk) begin
    if (en) begin
      zr[1] <= z1;
      for (int i = 2; i < PipeLat; i++) zr[i] <= zr[i-1];
    end
  end

  // divider lanes
  logic signed [OutW-1:0] q [0:5];

  for (genvar g = 0; g < 6; g++) begin : g_div
    pfcm_div_lane u_div (
      .clk (clk),
      .en  (en),
      .num (num3[g]),
      .den (den3),
      .quo (q[g])
    );
  end

  // symmetric block, row-major
  assign m_tdata = {q[5], q[4], q[2], q[4], q[3], q[1], q[2], q[1], q[0]};
  assign m_tuser = zr[PipeLat-1];

`ifndef SYNTHESIS
  a_zero_matrix: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("zero vector gave nonzero matrix");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed during stall");

  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while pipeline held");
`endif

endmodule

`default_nettype wire

FILE: rtl/pfcm_div_lane.sv
// ----------------------------------------------------------------------------
// pfcm_div_lane
// Pipelined rounding divider: q = round(256 * num / den), ties away from
// zero, one restoring step per stage. Advances only when en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module pfcm_div_lane (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [pfcm_pkg::NumW-1:0]  num,
  input  wire logic        [pfcm_pkg::N2W-1:0]   den,   // nonzero
  output logic signed      [pfcm_pkg::OutW-1:0]  quo
);
  import pfcm_pkg::*;

  localparam int RW = NumW + 10;   // 2*256*|num| + den
  localparam int DW = N2W + 1;     // 2*den

  logic [NumW-1:0] mag;
  logic [RW-1:0]   dividend;

  logic [RW-1:0]   rem  [0:QuoW];
  logic [QuoW-1:0] qacc [0:QuoW];
  logic [DW-1:0]   d2   [0:QuoW];
  logic            neg  [0:QuoW];

  logic [RW-1:0]   sh   [0:QuoW-1];
  logic            ge   [0:QuoW-1];

  // magnitude and rounded dividend
  always_comb begin
    mag      = num[NumW-1] ? NumW'(-num) : NumW'(num);
    dividend = {1'b0, mag, 9'b0} + RW'(den);
  end

  // per-stage trial subtract of the shifted divisor
  always_comb begin
    for (int s = 0; s < QuoW; s++) begin
      sh[s] = RW'(d2[s]) << (QuoW - 1 - s);
      ge[s] = rem[s] >= sh[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= dividend;
      qacc[0] <= '0;
      d2[0]   <= {den, 1'b0};
      neg[0]  <= num[NumW-1];
      for (int s = 0; s < QuoW; s++) begin
        rem[s+1]  <= ge[s] ? rem[s] - sh[s] : rem[s];
        qacc[s+1] <= qacc[s] | (QuoW'(ge[s]) << (QuoW - 1 - s));
        d2[s+1]   <= d2[s];
        neg[s+1]  <= neg[s];
      end
      // apply sign; magnitude stays well inside 32 bits
      quo <= neg[QuoW] ? -OutW'(qacc[QuoW]) : OutW'(qacc[QuoW]);
    end
  end

endmodule

`default_nettype wire
